// ===== sv/rotation_matrix_to_quaternion_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_macros
// Assertion macros shared by the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_MACROS_SVH

// Implication checked on every rising edge of clk, suspended during reset.
`define RMQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rotation matrix to quaternion check failed");

// Next-cycle implication, suspended during reset.
`define RMQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rotation matrix to quaternion check failed");

`endif

// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Constants shared by the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;

	// Branch codes reported with each result item.
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X     = 2'd1;
	localparam logic [1:0] BR_Y     = 2'd2;
	localparam logic [1:0] BR_Z     = 2'd3;

	// Bit positions in the result tuser.
	localparam int TUSER_SAT_BIT = 2;
	localparam int TUSER_WIDTH   = 3;

endpackage

// ===== sv/rotation_matrix_to_quaternion_unit.sv =====
// Each item passes the input register, root stages, divider set-up, divider stages and output.
// Throughput: one item per cycle if unstalled, set by one-bit-per-stage root and dividers.
// The whole pipeline advances together; a stalled result freezes every stage.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix in Q1.F to a unit quaternion by Shepperd's
// method, with a pipelined square root and three pipelined dividers.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
	parameter int COMPONENT_WIDTH = rmq_pkg::COMPONENT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// s_tdata from bit 0 up: row1_col1, row1_col2, row1_col3, row2_col1, row2_col2,
	// row2_col3, row3_col1, row3_col2, row3_col3, then zero padding.
	input  logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// m_tdata from bit 0 up: quat_x, quat_y, quat_z, quat_w.
	output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,
	// m_tuser from bit 0 up: branch_taken (2 bits), saturated (1 bit).
	output logic [rmq_pkg::TUSER_WIDTH-1:0] m_tuser
);
	import rmq_pkg::*;

	`include "rotation_matrix_to_quaternion_unit_macros.svh"

	localparam int W   = COMPONENT_WIDTH;
	localparam int F   = W - 1;
	localparam int ODW = ((4*W+7)/8)*8;
	localparam int RW  = F + 4;       // root remainder width
	localparam int NW  = 2*F + 4;     // divider remainder width
	localparam int QW  = F + 2;       // quotient width

	localparam logic signed [W-1:0] COMP_MAX = {1'b0, {F{1'b1}}};
	localparam logic signed [W-1:0] COMP_MIN = {1'b1, {F{1'b0}}};

	// Side information carried alongside the square root.
	typedef struct packed {
		logic [1:0]          branch;
		logic                radpos;
		logic signed [W:0]   d0;
		logic signed [W:0]   d1;
		logic signed [W:0]   d2;
	} sq_side_t;

	// Side information carried alongside the dividers.
	typedef struct packed {
		logic [1:0]  branch;
		logic        radpos;
		logic        rootzero;
		logic [F:0]  diag;
		logic [2:0]  neg;
		logic [2:0]  zero;
		logic [2:0]  ovf;
		logic [QW-1:0] dv;
	} dv_side_t;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ------------------------------------------------------------------
	// Stage 1: branch choice, radicand and off-diagonal terms.
	// ------------------------------------------------------------------
	logic signed [F+3:0] a [0:8];
	logic signed [F+3:0] trace, rad;
	logic signed [F+3:0] d0_c, d1_c, d2_c;
	logic [1:0]          br_c;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			a[i] = (F+4)'(signed'(s_tdata[i*W +: W]));
		end
		trace = a[0] + a[4] + a[8];
		if (trace > 0) begin
			br_c = BR_TRACE;
			rad  = (F+4)'(1 << F) + trace;
			d0_c = a[5] - a[7];
			d1_c = a[6] - a[2];
			d2_c = a[1] - a[3];
		end else if (a[0] >= a[4] && a[0] >= a[8]) begin
			br_c = BR_X;
			rad  = (F+4)'(1 << F) + a[0] - a[4] - a[8];
			d0_c = a[1] + a[3];
			d1_c = a[2] + a[6];
			d2_c = a[5] - a[7];
		end else if (a[4] > a[8]) begin
			br_c = BR_Y;
			rad  = (F+4)'(1 << F) + a[4] - a[0] - a[8];
			d0_c = a[3] + a[1];
			d1_c = a[7] + a[5];
			d2_c = a[6] - a[2];
		end else begin
			br_c = BR_Z;
			rad  = (F+4)'(1 << F) + a[8] - a[0] - a[4];
			d0_c = a[6] + a[2];
			d1_c = a[7] + a[5];
			d2_c = a[1] - a[3];
		end
	end

	logic         sq_v    [0:F+1];
	sq_side_t     sq_side [0:F+1];
	logic [F+1:0] sq_rad  [0:F+1];
	logic [RW-1:0] sq_rem [0:F+1];
	logic [F:0]   sq_root [0:F+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side[0].branch <= br_c;
			sq_side[0].radpos <= (rad > 0);
			sq_side[0].d0     <= d0_c[W:0];
			sq_side[0].d1     <= d1_c[W:0];
			sq_side[0].d2     <= d2_c[W:0];
			// A radicand that is not positive takes a root of zero.
			sq_rad[0]         <= (rad > 0) ? rad[F+1:0] : '0;
			sq_rem[0]         <= '0;
			sq_root[0]        <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Square root of rad * 2^F, one result bit per stage.
	// ------------------------------------------------------------------
	for (genvar j = 0; j <= F; j++) begin : g_sqrt
		logic [2*F+1:0] radn;
		logic [1:0]     pair;
		logic [RW-1:0]  rem_sh, trial;
		logic           take;

		always_comb begin
			radn   = {sq_rad[j], {F{1'b0}}};
			pair   = radn[2*(F-j) +: 2];
			rem_sh = {sq_rem[j][RW-3:0], pair};
			trial  = RW'({sq_root[j], 2'b01});
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else if (en) begin
				sq_v[j+1] <= sq_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side[j+1] <= sq_side[j];
				sq_rad[j+1]  <= sq_rad[j];
				sq_rem[j+1]  <= take ? (rem_sh - trial) : rem_sh;
				sq_root[j+1] <= {sq_root[j][F-1:0], take};
			end
		end
	end

	// ------------------------------------------------------------------
	// Divider set-up: numerators, divisor, overflow and the diagonal term.
	// ------------------------------------------------------------------
	logic [F:0]   root_f;
	logic signed [W:0] dl [0:2];
	logic [W:0]   mag [0:2];
	logic [NW-1:0] num_c [0:2];
	logic [QW-1:0] dv_c;
	logic [NW-1:0] dv_top;

	always_comb begin
		root_f = sq_root[F+1];
		dl[0]  = sq_side[F+1].d0;
		dl[1]  = sq_side[F+1].d1;
		dl[2]  = sq_side[F+1].d2;
		dv_c   = {root_f, 1'b0};
		dv_top = NW'(dv_c) << QW;
		for (int i = 0; i < 3; i++) begin
			mag[i]   = dl[i][W] ? (W+1)'(-dl[i]) : dl[i];
			num_c[i] = (NW'(mag[i]) << F) + NW'(root_f);
		end
	end

	logic          dv_v    [0:QW];
	dv_side_t      dv_side [0:QW];
	logic [NW-1:0] dv_rem  [0:2][0:QW];
	logic [QW-1:0] dv_q    [0:2][0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[F+1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side[0].branch   <= sq_side[F+1].branch;
			dv_side[0].radpos   <= sq_side[F+1].radpos;
			dv_side[0].rootzero <= (root_f == '0);
			dv_side[0].diag     <= (F+1)'(({1'b0, root_f} + (F+2)'(1)) >> 1);
			dv_side[0].dv       <= dv_c;
			for (int i = 0; i < 3; i++) begin
				dv_side[0].neg[i]  <= dl[i][W];
				dv_side[0].zero[i] <= (dl[i] == '0);
				dv_side[0].ovf[i]  <= (num_c[i] >= dv_top);
				dv_rem[i][0]       <= num_c[i];
				dv_q[i][0]         <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Restoring dividers, one quotient bit per stage, three lanes.
	// ------------------------------------------------------------------
	for (genvar s = 0; s < QW; s++) begin : g_div
		logic [NW-1:0] trial;
		logic [2:0]    take;

		always_comb begin
			trial = NW'(dv_side[s].dv) << (QW-1-s);
			for (int i = 0; i < 3; i++) begin
				take[i] = (dv_rem[i][s] >= trial);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[s+1] <= 1'b0;
			end else if (en) begin
				dv_v[s+1] <= dv_v[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side[s+1] <= dv_side[s];
				for (int i = 0; i < 3; i++) begin
					dv_rem[i][s+1] <= take[i] ? (dv_rem[i][s] - trial) : dv_rem[i][s];
					dv_q[i][s+1]   <= {dv_q[i][s][QW-2:0], take[i]};
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output stage: signs, clipping, zero root and component placement.
	// ------------------------------------------------------------------
	dv_side_t          fs;
	logic signed [W-1:0] cval [0:2];
	logic [2:0]        cflag;
	logic signed [W-1:0] diag_v;
	logic              diag_flag;
	logic signed [W-1:0] qx, qy, qz, qw;
	logic              sat_c;

	always_comb begin
		fs = dv_side[QW];
		for (int i = 0; i < 3; i++) begin
			if (fs.rootzero) begin
				cflag[i] = 1'b1;
				cval[i]  = fs.zero[i] ? '0 : (fs.neg[i] ? COMP_MIN : COMP_MAX);
			end else if (fs.ovf[i] || dv_q[i][QW] > QW'(1 << F)) begin
				cflag[i] = 1'b1;
				cval[i]  = fs.neg[i] ? COMP_MIN : COMP_MAX;
			end else if (dv_q[i][QW] == QW'(1 << F)) begin
				// Exactly minus one is representable, plus one is not.
				cflag[i] = !fs.neg[i];
				cval[i]  = fs.neg[i] ? COMP_MIN : COMP_MAX;
			end else begin
				cflag[i] = 1'b0;
				cval[i]  = fs.neg[i] ? W'(-dv_q[i][QW][F-1:0]) : W'(dv_q[i][QW][F-1:0]);
			end
		end
		if (!fs.radpos) begin
			diag_v    = '0;
			diag_flag = 1'b1;
		end else if (fs.diag[F]) begin
			diag_v    = COMP_MAX;
			diag_flag = 1'b1;
		end else begin
			diag_v    = W'(fs.diag);
			diag_flag = 1'b0;
		end
		case (fs.branch)
			BR_TRACE: begin
				qx = cval[0]; qy = cval[1]; qz = cval[2]; qw = diag_v;
			end
			BR_X: begin
				qx = diag_v; qy = cval[0]; qz = cval[1]; qw = cval[2];
			end
			BR_Y: begin
				qx = cval[0]; qy = diag_v; qz = cval[1]; qw = cval[2];
			end
			default: begin
				qx = cval[0]; qy = cval[1]; qz = diag_v; qw = cval[2];
			end
		endcase
		sat_c = diag_flag | (|cflag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= ODW'({qw, qz, qy, qx});
			m_tuser <= {sat_c, fs.branch};
		end
	end

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`RMQ_ASSERT_IMP(a_zero_root_for_bad_radicand, sq_v[F+1] && !sq_side[F+1].radpos, root_f == '0)
	`RMQ_ASSERT_IMP(a_ready_follows_output, !m_tready && m_tvalid, !s_tready)
	`RMQ_ASSERT_IMP(a_trace_w_nonneg, m_tvalid && !m_tuser[TUSER_SAT_BIT] && m_tuser[1:0] == BR_TRACE, !m_tdata[4*W-1])

endmodule
